// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// shared types, sizes and codes of the hashed position table
// ----------------------------------------------------------------------------
package hpt_pkg;

  // table geometry
  localparam int INDEX_BITS = 16;
  localparam int SLOT_COUNT = 1 << INDEX_BITS;
  localparam int KEY_W      = 64;
  localparam int TAG_W      = KEY_W - INDEX_BITS;

  // field widths
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;
  localparam int SQ_W    = 6;
  localparam int PROMO_W = 3;
  localparam int PLY_W   = 8;
  localparam int GEN_W   = 8;

  // score arithmetic, wide enough for a full-range score plus ply
  localparam int SCORE_EXT_W = SCORE_W + 2;
  localparam int MATE_LIMIT  = 30744;
  localparam int SCORE_MAX   = 32767;
  localparam logic signed [SCORE_EXT_W-1:0] MATE_POS  = SCORE_EXT_W'(MATE_LIMIT);
  localparam logic signed [SCORE_EXT_W-1:0] MATE_NEG  = -SCORE_EXT_W'(MATE_LIMIT);
  localparam logic signed [SCORE_EXT_W-1:0] SCORE_POS = SCORE_EXT_W'(SCORE_MAX);
  localparam logic signed [SCORE_EXT_W-1:0] SCORE_NEG = -SCORE_EXT_W'(SCORE_MAX);

  // operation codes
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // one accepted input item
  typedef struct packed {
    logic                      op;
    logic [KEY_W-1:0]          position_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic signed [SCORE_W-1:0] node_score;
    logic [BOUND_W-1:0]        bound_kind;
    logic [SQ_W-1:0]           from_square;
    logic [SQ_W-1:0]           to_square;
    logic [PROMO_W-1:0]        promotion;
    logic [PLY_W-1:0]          ply_from_root;
  } hpt_req_t;

  // one result item
  typedef struct packed {
    logic                      hit;
    logic                      written;
    logic [DEPTH_W-1:0]        entry_depth;
    logic signed [SCORE_W-1:0] entry_score;
    logic [BOUND_W-1:0]        entry_bound;
    logic [SQ_W-1:0]           entry_from;
    logic [SQ_W-1:0]           entry_to;
    logic [PROMO_W-1:0]        entry_promotion;
  } hpt_rsp_t;

  // one table slot; the full key is kept so a cleared slot holds key zero
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [SQ_W-1:0]           from_sq;
    logic [SQ_W-1:0]           to_sq;
    logic [PROMO_W-1:0]        promo;
    logic [GEN_W-1:0]          gen;
  } hpt_entry_t;

  localparam int ENTRY_W = $bits(hpt_entry_t);

  // clear sequencer
  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } hpt_clr_state_t;

  typedef struct packed {
    logic                  active;
    logic                  we;
    logic [INDEX_BITS-1:0] addr;
  } hpt_clr_t;

endpackage

// ===== rtl/hpt_in_if.sv =====
// ----------------------------------------------------------------------------
// hpt_in_if
// request channel of the hashed position table
// ----------------------------------------------------------------------------
interface hpt_in_if;
  import hpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [KEY_W-1:0]          position_key;
  logic [DEPTH_W-1:0]        search_depth;
  logic signed [SCORE_W-1:0] node_score;
  logic [BOUND_W-1:0]        bound_kind;
  logic [SQ_W-1:0]           from_square;
  logic [SQ_W-1:0]           to_square;
  logic [PROMO_W-1:0]        promotion;
  logic [PLY_W-1:0]          ply_from_root;

  modport source (
    output valid, op, position_key, search_depth, node_score, bound_kind,
           from_square, to_square, promotion, ply_from_root,
    input  ready
  );

  modport sink (
    input  valid, op, position_key, search_depth, node_score, bound_kind,
           from_square, to_square, promotion, ply_from_root,
    output ready
  );

endinterface

// ===== rtl/hpt_out_if.sv =====
// ----------------------------------------------------------------------------
// hpt_out_if
// result channel of the hashed position table
// ----------------------------------------------------------------------------
interface hpt_out_if;
  import hpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      written;
  logic [DEPTH_W-1:0]        entry_depth;
  logic signed [SCORE_W-1:0] entry_score;
  logic [BOUND_W-1:0]        entry_bound;
  logic [SQ_W-1:0]           entry_from;
  logic [SQ_W-1:0]           entry_to;
  logic [PROMO_W-1:0]        entry_promotion;

  modport source (
    output valid, hit, written, entry_depth, entry_score, entry_bound,
           entry_from, entry_to, entry_promotion,
    input  ready
  );

  modport sink (
    input  valid, hit, written, entry_depth, entry_score, entry_bound,
           entry_from, entry_to, entry_promotion,
    output ready
  );

endinterface

// ===== rtl/hpt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hpt_cfg_if
// configuration write channel of the hashed position table
// ----------------------------------------------------------------------------
interface hpt_cfg_if;
  import hpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [GEN_W-1:0] search_generation;

  modport source (
    output valid, search_generation,
    input  ready
  );

  modport sink (
    input  valid, search_generation,
    output ready
  );

endinterface

// ===== rtl/hpt_ram.sv =====
// ----------------------------------------------------------------------------
// hpt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hpt_clear.sv =====
// ----------------------------------------------------------------------------
// hpt_clear
// post-reset sweep that zeroes every slot of the table
// ----------------------------------------------------------------------------
module hpt_clear (
  input  logic              clk,
  input  logic              rst_n,
  output hpt_pkg::hpt_clr_t clr
);
  import hpt_pkg::*;

  hpt_clr_state_t        state_r, state_nxt;
  logic [INDEX_BITS-1:0] addr_r, addr_nxt;
  logic                  last;

  assign last = (addr_r == {INDEX_BITS{1'b1}});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CLR_SWEEP: if (last) state_nxt = CLR_DONE;
      CLR_DONE:  state_nxt = CLR_DONE;
      default:   state_nxt = CLR_DONE;
    endcase
  end

  always_comb begin
    clr.active = 1'b0;
    clr.we     = 1'b0;
    clr.addr   = addr_r;
    addr_nxt   = addr_r;
    unique case (state_r)
      CLR_SWEEP: begin
        clr.active = 1'b1;
        clr.we     = 1'b1;
        addr_nxt   = addr_r + 1'b1;
      end
      CLR_DONE: begin
        clr.active = 1'b0;
      end
      default: begin
        clr.active = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CLR_SWEEP;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// ===== rtl/hpt_update.sv =====
// ----------------------------------------------------------------------------
// hpt_update
// slot compare, replacement decision, mate adjustment and result forming
// ----------------------------------------------------------------------------
module hpt_update (
  input  hpt_pkg::hpt_req_t            item,
  input  hpt_pkg::hpt_entry_t          entry,
  input  logic [hpt_pkg::GEN_W-1:0]    gen,
  output logic                         we,
  output hpt_pkg::hpt_entry_t          new_entry,
  output hpt_pkg::hpt_rsp_t            rsp
);
  import hpt_pkg::*;

  logic                          tag_match;
  logic                          keep;
  logic signed [SCORE_EXT_W-1:0] s_ext;
  logic signed [SCORE_EXT_W-1:0] ply_ext;
  logic signed [SCORE_EXT_W-1:0] s_adj;
  logic signed [SCORE_EXT_W-1:0] s_sat;

  assign tag_match = (entry.key == item.position_key);
  assign keep      = tag_match && (entry.gen == gen) && (entry.depth > item.search_depth);

  // mate scores move outward by the distance from the root, then saturate
  assign s_ext   = SCORE_EXT_W'(item.node_score);
  assign ply_ext = {{(SCORE_EXT_W-PLY_W){1'b0}}, item.ply_from_root};

  always_comb begin
    priority if (s_ext > MATE_POS) begin
      s_adj = s_ext + ply_ext;
    end else if (s_ext < MATE_NEG) begin
      s_adj = s_ext - ply_ext;
    end else begin
      s_adj = s_ext;
    end
    priority if (s_adj > SCORE_POS) begin
      s_sat = SCORE_POS;
    end else if (s_adj < SCORE_NEG) begin
      s_sat = SCORE_NEG;
    end else begin
      s_sat = s_adj;
    end
  end

  always_comb begin
    new_entry.key     = item.position_key;
    new_entry.depth   = item.search_depth;
    new_entry.score   = s_sat[SCORE_W-1:0];
    new_entry.bound   = item.bound_kind;
    new_entry.from_sq = item.from_square;
    new_entry.to_sq   = item.to_square;
    new_entry.promo   = item.promotion;
    new_entry.gen     = gen;
  end

  always_comb begin
    rsp = '0;
    we  = 1'b0;
    unique case (item.op)
      OP_STORE: begin
        we          = !keep;
        rsp.written = !keep;
      end
      OP_PROBE: begin
        if (tag_match) begin
          rsp.hit             = 1'b1;
          rsp.entry_depth     = entry.depth;
          rsp.entry_score     = entry.score;
          rsp.entry_bound     = entry.bound;
          rsp.entry_from      = entry.from_sq;
          rsp.entry_to        = entry.to_sq;
          rsp.entry_promotion = entry.promo;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

// ===== rtl/hashed_position_table_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_position_table_unit
// direct-mapped position table with depth-preferred replacement
// ----------------------------------------------------------------------------
// Each request transaction is a probe or a store and yields exactly one result
// transaction. The slot is picked by the low INDEX_BITS bits of the key and
// lives in one single-port-read, single-port-write ram with a registered
// read. A transaction is read in the cycle it is accepted, then compared,
// updated and written back when its result enters the output register,
// which can wait while the receiver stalls; that slot read-modify-write sets
// the pace: one transaction per cycle while results are taken. A store that
// lands on the slot the following transaction reads is forwarded. After
// reset the table is swept to zero, one slot per cycle, through all
// 2**INDEX_BITS slots (65536 at the default size); requests wait during the
// sweep, generation writes are taken at any time.
module hashed_position_table_unit (
  input  logic clk,
  input  logic rst_n,
  hpt_in_if.sink    in_ch,
  hpt_out_if.source out_ch,
  hpt_cfg_if.sink   cfg_ch
);
  import hpt_pkg::*;

  // configuration
  logic [GEN_W-1:0] gen_r;

  // clear sweep
  hpt_clr_t clr;

  // request side
  logic                  in_fire;
  hpt_req_t              in_req;
  hpt_req_t              item_r;
  logic                  busy_r;
  logic                  push;

  // ram ports
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  hpt_entry_t            ram_wdata;
  hpt_entry_t            ram_rdata;
  logic [INDEX_BITS-1:0] item_idx;
  logic [INDEX_BITS-1:0] in_idx;

  // forwarding of a write to the slot just read
  logic                  fwd_valid_r;
  hpt_entry_t            fwd_data_r;
  hpt_entry_t            cur_entry;

  // update result
  logic                  upd_we;
  hpt_entry_t            upd_entry;
  hpt_rsp_t              upd_rsp;

  // output register
  logic                  out_valid_r;
  hpt_rsp_t              out_rsp_r;

  // generation register, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
    end else if (cfg_ch.valid) begin
      gen_r <= cfg_ch.search_generation;
    end
  end

  hpt_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr)
  );

  // gather the request fields
  always_comb begin
    in_req.op            = in_ch.op;
    in_req.position_key  = in_ch.position_key;
    in_req.search_depth  = in_ch.search_depth;
    in_req.node_score    = in_ch.node_score;
    in_req.bound_kind    = in_ch.bound_kind;
    in_req.from_square   = in_ch.from_square;
    in_req.to_square     = in_ch.to_square;
    in_req.promotion     = in_ch.promotion;
    in_req.ply_from_root = in_ch.ply_from_root;
  end

  assign in_idx   = in_ch.position_key[INDEX_BITS-1:0];
  assign item_idx = item_r.position_key[INDEX_BITS-1:0];

  // result moves into the output register when it is free or being drained
  assign push        = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clr.active && (!busy_r || push);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // slot contents, with the write of the previous transaction forwarded
  assign cur_entry = fwd_valid_r ? fwd_data_r : ram_rdata;

  hpt_update u_update (
    .item      (item_r),
    .entry     (cur_entry),
    .gen       (gen_r),
    .we        (upd_we),
    .new_entry (upd_entry),
    .rsp       (upd_rsp)
  );

  // write port: clear sweep first, then write-back of the finished store
  always_comb begin
    if (clr.active) begin
      ram_we    = clr.we;
      ram_waddr = clr.addr;
      ram_wdata = '0;
    end else begin
      ram_we    = push && upd_we;
      ram_waddr = item_idx;
      ram_wdata = upd_entry;
    end
  end

  hpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // item register and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r      <= 1'b1;
        fwd_valid_r <= ram_we && (ram_waddr == in_idx);
      end else if (push) begin
        busy_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r     <= in_req;
      fwd_data_r <= ram_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_rsp_r <= upd_rsp;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.hit             = out_rsp_r.hit;
  assign out_ch.written         = out_rsp_r.written;
  assign out_ch.entry_depth     = out_rsp_r.entry_depth;
  assign out_ch.entry_score     = out_rsp_r.entry_score;
  assign out_ch.entry_bound     = out_rsp_r.entry_bound;
  assign out_ch.entry_from      = out_rsp_r.entry_from;
  assign out_ch.entry_to        = out_rsp_r.entry_to;
  assign out_ch.entry_promotion = out_rsp_r.entry_promotion;

`ifndef SYNTHESIS
  // no transaction may enter while the sweep owns the write port
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.active |-> !in_fire)
    else $error("request accepted during table clear");

  // an accepted transaction always occupies the update stage next cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r)
    else $error("accepted transaction lost before update");

  // probes never modify the table
  a_probe_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr.active && busy_r && item_r.op == OP_PROBE) |-> !ram_we)
    else $error("probe wrote the table");

  // a result never reports both a hit and a write
  a_hit_or_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.hit && out_rsp_r.written))
    else $error("result flags both hit and written");
`endif

endmodule

// ===== tb/tb_hashed_position_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hashed_position_table_unit
// self-checking bench for the hashed position table
// ----------------------------------------------------------------------------
// Probe and store transactions go in through the request channel. A shadow
// copy of the table predicts every result at the moment its request is
// accepted, and a checker compares each result transaction with the oldest
// prediction, field by field. Directed tests cover the empty table, field
// extremes, mate score adjustment and saturation, depth-preferred replacement
// and generation wrap; random phases then mix stores and probes, mostly on a
// small pool of colliding keys, under random idling, a long receiver stall
// and a sender pause.
module tb_hashed_position_table_unit;
  import hpt_pkg::*;

  // shadow copy of one table slot, full key kept
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [SQ_W-1:0]           from_sq;
    logic [SQ_W-1:0]           to_sq;
    logic [PROMO_W-1:0]        promo;
    logic [GEN_W-1:0]          gen;
  } shadow_slot_t;

  logic clk;
  logic rst_n;

  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();
  hpt_cfg_if cfg_ch ();

  hashed_position_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow table; a slot never written reads as all zero
  shadow_slot_t     shadow_table [int unsigned];
  logic [GEN_W-1:0] shadow_generation = '0;

  // predicted results, oldest first
  hpt_rsp_t pending_results [$];

  // small key pools so that keys collide on slots and repeat
  logic [INDEX_BITS-1:0] slot_pool [8];
  logic [TAG_W-1:0]      tag_pool [4];

  int fail_count = 0;
  bit sender_idles = 1'b1;
  bit taker_idles = 1'b1;
  int taker_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // the run is far shorter than this even with the clearing sweep
  initial begin
    #2_000_000;
    $display("tb_hashed_position_table_unit failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // mate scores move outward by the ply, then everything clamps to +-SCORE_MAX
  function automatic logic signed [SCORE_W-1:0] mate_adjusted(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply
  );
    int v;
    int p;
    v = s;
    p = ply;
    if (v > MATE_LIMIT) v = v + p;
    else if (v < -MATE_LIMIT) v = v - p;
    if (v > SCORE_MAX) v = SCORE_MAX;
    if (v < -SCORE_MAX) v = -SCORE_MAX;
    return SCORE_W'(v);
  endfunction

  // applies one request to the shadow table and returns its result
  function automatic hpt_rsp_t table_outcome(input hpt_req_t r);
    hpt_rsp_t     res;
    shadow_slot_t s;
    int unsigned  idx;
    res = '0;
    idx = 32'(r.position_key[INDEX_BITS-1:0]);
    if (shadow_table.exists(idx)) s = shadow_table[idx];
    else s = '0;
    if (r.op == OP_PROBE) begin
      if (s.key == r.position_key) begin
        res.hit             = 1'b1;
        res.entry_depth     = s.depth;
        res.entry_score     = s.score;
        res.entry_bound     = s.bound;
        res.entry_from      = s.from_sq;
        res.entry_to        = s.to_sq;
        res.entry_promotion = s.promo;
      end
      return res;
    end
    // a deeper result for the same key from this search is kept
    if (s.key == r.position_key && s.gen == shadow_generation && s.depth > r.search_depth)
      return res;
    s.key     = r.position_key;
    s.depth   = r.search_depth;
    s.score   = mate_adjusted(r.node_score, r.ply_from_root);
    s.bound   = r.bound_kind;
    s.from_sq = r.from_square;
    s.to_sq   = r.to_square;
    s.promo   = r.promotion;
    s.gen     = shadow_generation;
    shadow_table[idx] = s;
    res.written = 1'b1;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // valid stays high between back-to-back transactions, lowered only for a gap
  task automatic send_request(input hpt_req_t r);
    int gap;
    gap = sender_idles ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= r.op;
    in_ch.position_key  <= r.position_key;
    in_ch.search_depth  <= r.search_depth;
    in_ch.node_score    <= r.node_score;
    in_ch.bound_kind    <= r.bound_kind;
    in_ch.from_square   <= r.from_square;
    in_ch.to_square     <= r.to_square;
    in_ch.promotion     <= r.promotion;
    in_ch.ply_from_root <= r.ply_from_root;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), table_outcome(r));
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // only called with the block idle
  task automatic set_generation(input logic [GEN_W-1:0] g);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.search_generation <= g;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_generation = g;
  endtask

  function automatic hpt_req_t make_store(
    input logic [KEY_W-1:0] key, input int depth, input int score, input int bound,
    input int from_sq, input int to_sq, input int promo, input int ply
  );
    hpt_req_t r;
    r.op            = OP_STORE;
    r.position_key  = key;
    r.search_depth  = DEPTH_W'(depth);
    r.node_score    = SCORE_W'(score);
    r.bound_kind    = BOUND_W'(bound);
    r.from_square   = SQ_W'(from_sq);
    r.to_square     = SQ_W'(to_sq);
    r.promotion     = PROMO_W'(promo);
    r.ply_from_root = PLY_W'(ply);
    return r;
  endfunction

  function automatic hpt_req_t make_probe(input logic [KEY_W-1:0] key);
    hpt_req_t r;
    r = '0;
    r.op = OP_PROBE;
    r.position_key = key;
    return r;
  endfunction

  // ordinary scores, scores near and past the mate limit, raw 16-bit values
  function automatic logic signed [SCORE_W-1:0] random_score();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 64000)) - 32000;
      4, 5: v = int'($urandom_range(30700, 32000));
      6, 7: v = -int'($urandom_range(30700, 32000));
      8: v = ($urandom_range(0, 1) ? 1 : -1) * (MATE_LIMIT + int'($urandom_range(0, 1)));
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return SCORE_W'(v);
  endfunction

  function automatic hpt_req_t random_request();
    hpt_req_t r;
    r.op = ($urandom_range(0, 99) < 55) ? OP_STORE : OP_PROBE;
    if ($urandom_range(0, 9) < 7)
      r.position_key = {tag_pool[$urandom_range(0, 3)], slot_pool[$urandom_range(0, 7)]};
    else
      r.position_key = {$urandom, $urandom};
    r.search_depth  = DEPTH_W'($urandom_range(0, 127));
    r.node_score    = random_score();
    r.bound_kind    = BOUND_W'($urandom_range(0, 3));
    r.from_square   = SQ_W'($urandom_range(0, 63));
    r.to_square     = SQ_W'($urandom_range(0, 63));
    r.promotion     = PROMO_W'($urandom_range(0, 7));
    r.ply_from_root = PLY_W'($urandom_range(0, 255));
    return r;
  endfunction

  // random traffic; a store is followed by a probe of the same key at random
  task automatic send_random_traffic(input int count);
    hpt_req_t r;
    int       sent;
    sent = 0;
    while (sent < count) begin
      r = random_request();
      send_request(r);
      sent++;
      if (r.op == OP_STORE && $urandom_range(0, 1)) begin
        send_request(make_probe(r.position_key));
        sent++;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  // receiver: random gaps, plus a long hold when a test asks for one
  initial begin : result_taker
    int gap;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taker_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (taker_hold_cycles) @(posedge clk);
        taker_hold_cycles = 0;
      end
      gap = taker_idles ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : result_checker
    hpt_rsp_t got;
    hpt_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit             = out_ch.hit;
      got.written         = out_ch.written;
      got.entry_depth     = out_ch.entry_depth;
      got.entry_score     = out_ch.entry_score;
      got.entry_bound     = out_ch.entry_bound;
      got.entry_from      = out_ch.entry_from;
      got.entry_to        = out_ch.entry_to;
      got.entry_promotion = out_ch.entry_promotion;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result transaction with nothing expected: %h", got));
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", got.hit, want.hit);
        compare_field("written", got.written, want.written);
        compare_field("entry_depth", got.entry_depth, want.entry_depth);
        compare_field("entry_score", got.entry_score, want.entry_score);
        compare_field("entry_bound", got.entry_bound, want.entry_bound);
        compare_field("entry_from", got.entry_from, want.entry_from);
        compare_field("entry_to", got.entry_to, want.entry_to);
        compare_field("entry_promotion", got.entry_promotion, want.entry_promotion);
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // fresh table: key 0 hits slot 0 with zero fields, other keys miss
  task automatic test_empty_table();
    send_request(make_probe(64'h0));
    send_request(make_probe({{TAG_W{1'b0}}, {INDEX_BITS{1'b1}}}));
    send_request(make_probe(64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  task automatic test_field_extremes();
    send_request(make_store(64'hFFFF_FFFF_FFFF_FFFF, 127, 32000, 3, 63, 63, 7, 255));
    send_request(make_probe(64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_store(64'h8000_0000_0000_0001, 0, -32000, 0, 0, 0, 0, 0));
    send_request(make_probe(64'h8000_0000_0000_0001));
  endtask

  // at the limit nothing moves; past it the score moves outward by the ply; extremes saturate
  task automatic test_mate_scores();
    send_request(make_store(64'h0123_4567_89AB_0010, 9, 30744, 1, 12, 28, 0, 200));
    send_request(make_probe(64'h0123_4567_89AB_0010));
    send_request(make_store(64'h0123_4567_89AB_0011, 9, -30745, 2, 52, 60, 5, 9));
    send_request(make_probe(64'h0123_4567_89AB_0011));
    send_request(make_store(64'h0123_4567_89AB_0012, 9, 32767, 1, 8, 0, 4, 1));
    send_request(make_probe(64'h0123_4567_89AB_0012));
    send_request(make_store(64'h0123_4567_89AB_0013, 9, -32768, 3, 1, 2, 3, 0));
    send_request(make_probe(64'h0123_4567_89AB_0013));
  endtask

  // same key, current generation: shallower store is dropped, equal depth wins
  task automatic test_replacement();
    send_request(make_store(64'hDEAD_BEEF_CAFE_0042, 20, 150, 1, 11, 27, 0, 4));
    send_request(make_store(64'hDEAD_BEEF_CAFE_0042, 10, -75, 2, 12, 28, 0, 5));
    send_request(make_store(64'hDEAD_BEEF_CAFE_0042, 20, 33, 3, 6, 21, 0, 6));
    send_request(make_probe(64'hDEAD_BEEF_CAFE_0042));
    send_request(make_store(64'h1111_2222_3333_0042, 1, 7, 1, 48, 56, 2, 7));
  endtask

  // the tag wraps from 255 to 0 and only equality counts
  task automatic test_generation_wrap();
    wait_for_results();
    set_generation(8'd255);
    send_request(make_store(64'h0F0F_0F0F_0F0F_7777, 60, 500, 1, 3, 19, 0, 2));
    wait_for_results();
    set_generation(8'd0);
    send_request(make_store(64'h0F0F_0F0F_0F0F_7777, 5, -500, 2, 4, 20, 0, 2));
    send_request(make_store(64'h0F0F_0F0F_0F0F_7777, 3, 42, 3, 5, 21, 0, 2));
    send_request(make_probe(64'h0F0F_0F0F_0F0F_7777));
  endtask

  // one search: new generation, then random traffic under one idling mix
  task automatic test_random_search(input int phase);
    logic [GEN_W-1:0] gen;
    case (phase)
      0: gen = 8'd1;
      1: gen = 8'd255;
      2: gen = 8'd0;
      4: gen = 8'd1;
      default: gen = GEN_W'($urandom_range(0, 255));
    endcase
    wait_for_results();
    set_generation(gen);
    sender_idles = phase[0];
    taker_idles  = phase[1];
    send_random_traffic(150);
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    sender_idles = 1'b0;
    taker_idles  = 1'b0;
    taker_hold_cycles = 300;
    send_random_traffic(80);
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    sender_idles = 1'b1;
    taker_idles  = 1'b1;
    send_random_traffic(20);
    wait_for_results();
    send_random_traffic(20);
  endtask

  initial begin : stimulus
    int i;
    // slot 0 and the top slot always in the pool, tag 0 and all ones too
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (i = 2; i < 8; i++) slot_pool[i] = INDEX_BITS'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (i = 2; i < 4; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});

    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.op                 <= OP_PROBE;
    in_ch.position_key       <= '0;
    in_ch.search_depth       <= '0;
    in_ch.node_score         <= '0;
    in_ch.bound_kind         <= '0;
    in_ch.from_square        <= '0;
    in_ch.to_square          <= '0;
    in_ch.promotion          <= '0;
    in_ch.ply_from_root      <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.search_generation <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // first requests wait out the clearing sweep
    test_empty_table();
    test_field_extremes();
    test_mate_scores();
    test_replacement();
    test_generation_wrap();
    for (i = 0; i < 6; i++) test_random_search(i);
    test_backpressure();
    test_sender_pause();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("tb_hashed_position_table_unit passed");
    end else begin
      $display("tb_hashed_position_table_unit failed");
    end
    $finish;
  end

endmodule
